// File: rtl/core/sti_pkg.sv
// shared types and constants for the spectral tristimulus integrator
// no dependencies
package sti_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int WEIGHT_W     = 16;
  localparam int PROD_W       = SAMPLE_W + WEIGHT_W;
  localparam int ACC_W        = 42;
  localparam int TARGET_W     = 10;
  localparam int NUM_W        = ACC_W + TARGET_W;
  localparam int OUT_W        = 16;
  localparam int STATUS_W     = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(100);
  localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};
  localparam logic [OUT_W-1:0]    OUT_MAX      = {OUT_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_YZERO = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  // finished spectrum sums handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
    logic [ACC_W-1:0] z;
  } sums_t;

endpackage

// File: rtl/core/spectral_tristimulus_integrator_core.sv
// bins are accepted one per cycle unless the front stalls; after a spectrum's last
// bin is accepted its result goes through accumulate into queue, multiply, check,
// 16 divide steps and output; the back end takes new sums only when idle and skips
// the divide steps when the y sum is zero; the sum queue absorbs bursts of short
// spectra, and the front stalls only when it is full; synchronous reset clears the
// sums, the queue and the output valid, and sets the target to 100
module spectral_tristimulus_integrator_core #(
  parameter int QUEUE_DEPTH = sti_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [sti_pkg::TARGET_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sti_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic [sti_pkg::WEIGHT_W-1:0]      in_weight_x,
  input  logic [sti_pkg::WEIGHT_W-1:0]      in_weight_y,
  input  logic [sti_pkg::WEIGHT_W-1:0]      in_weight_z,
  input  logic                              in_last_bin,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sti_pkg::OUT_W-1:0]         out_tristimulus_x,
  output logic [sti_pkg::OUT_W-1:0]         out_tristimulus_z,
  output logic [sti_pkg::STATUS_W-1:0]      out_status
);

  logic [sti_pkg::TARGET_W-1:0] luminance_target_r;
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  sti_pkg::sums_t               q_wr_data;
  sti_pkg::sums_t               q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luminance_target_r <= sti_pkg::TARGET_RESET;
    end else if (cfg_wr_en) begin
      luminance_target_r <= cfg_wr_data;
    end
  end

  sti_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_weight_x (in_weight_x),
    .in_weight_y (in_weight_y),
    .in_weight_z (in_weight_z),
    .in_last_bin (in_last_bin),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_data      (q_wr_data)
  );

  sti_queue #(
    .WIDTH ($bits(sti_pkg::sums_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  sti_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .target            (luminance_target_r),
    .q_valid           (q_valid),
    .q_data            (q_rd_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tristimulus_x (out_tristimulus_x),
    .out_tristimulus_z (out_tristimulus_z),
    .out_status        (out_status)
  );

endmodule

// File: rtl/core/sti_front.sv
// front end: accepts bins, multiplies and accumulates, pushes finished sums
// depends on sti_pkg
module sti_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sti_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic [sti_pkg::WEIGHT_W-1:0]      in_weight_x,
  input  logic [sti_pkg::WEIGHT_W-1:0]      in_weight_y,
  input  logic [sti_pkg::WEIGHT_W-1:0]      in_weight_z,
  input  logic                              in_last_bin,
  output logic                              q_push,
  input  logic                              q_full,
  output sti_pkg::sums_t                    q_data
);

  logic                        p_valid_r;
  logic                        p_last_r;
  logic [sti_pkg::PROD_W-1:0]  prod_x_r;
  logic [sti_pkg::PROD_W-1:0]  prod_y_r;
  logic [sti_pkg::PROD_W-1:0]  prod_z_r;
  sti_pkg::sums_t              sums_r;
  sti_pkg::sums_t              sums_nxt;
  logic                        advance;

  function automatic logic [sti_pkg::ACC_W-1:0] sat_add(
    input logic [sti_pkg::ACC_W-1:0]  acc,
    input logic [sti_pkg::PROD_W-1:0] prod
  );
    logic [sti_pkg::ACC_W:0] s;
    s = {1'b0, acc} + (sti_pkg::ACC_W+1)'(prod);
    return s[sti_pkg::ACC_W] ? sti_pkg::ACC_MAX : s[sti_pkg::ACC_W-1:0];
  endfunction

  always_comb begin
    sums_nxt.x = sat_add(sums_r.x, prod_x_r);
    sums_nxt.y = sat_add(sums_r.y, prod_y_r);
    sums_nxt.z = sat_add(sums_r.z, prod_z_r);
  end

  // hold the last bin while the queue is full
  assign advance  = !(p_valid_r && p_last_r && q_full);
  assign in_ready = advance;
  assign q_push   = p_valid_r && p_last_r && !q_full;
  assign q_data   = sums_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      sums_r    <= '0;
    end else begin
      if (advance) begin
        p_valid_r <= in_valid;
      end
      if (p_valid_r && advance) begin
        sums_r <= p_last_r ? '0 : sums_nxt;
      end
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      p_last_r <= in_last_bin;
      prod_x_r <= sti_pkg::PROD_W'(in_sample) * sti_pkg::PROD_W'(in_weight_x);
      prod_y_r <= sti_pkg::PROD_W'(in_sample) * sti_pkg::PROD_W'(in_weight_y);
      prod_z_r <= sti_pkg::PROD_W'(in_sample) * sti_pkg::PROD_W'(in_weight_z);
    end
  end

endmodule

// File: rtl/core/sti_queue.sv
// small fifo of finished spectrum sums between front and back
// depends on nothing but its parameters
module sti_queue #(
  parameter int WIDTH = 126,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/sti_back.sv
// back end: scales finished sums by target / y sum with a bit-serial divider
// depends on sti_pkg
module sti_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sti_pkg::TARGET_W-1:0]      target,
  input  logic                              q_valid,
  input  sti_pkg::sums_t                    q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sti_pkg::OUT_W-1:0]         out_tristimulus_x,
  output logic [sti_pkg::OUT_W-1:0]         out_tristimulus_z,
  output logic [sti_pkg::STATUS_W-1:0]      out_status
);

  localparam int NUM_W = sti_pkg::NUM_W;
  localparam int ACC_W = sti_pkg::ACC_W;
  localparam int OUT_W = sti_pkg::OUT_W;
  localparam int CNT_W = $clog2(OUT_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_OUT
  } state_t;

  state_t                  state_r;
  logic [NUM_W-1:0]        num_x_r;
  logic [NUM_W-1:0]        num_z_r;
  logic [ACC_W-1:0]        den_r;
  logic [ACC_W-1:0]        rem_x_r;
  logic [ACC_W-1:0]        rem_z_r;
  logic [OUT_W-1:0]        quo_x_r;
  logic [OUT_W-1:0]        quo_z_r;
  logic                    sat_x_r;
  logic                    sat_z_r;
  logic                    yzero_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        res_x_r;
  logic [OUT_W-1:0]        res_z_r;
  sti_pkg::status_t        status_r;

  logic [OUT_W-1:0]        lo_x;
  logic [OUT_W-1:0]        lo_z;
  logic [ACC_W:0]          trial_x;
  logic [ACC_W:0]          trial_z;
  logic                    ge_x;
  logic                    ge_z;
  logic                    chk_sat_x;
  logic                    chk_sat_z;
  logic                    out_free;

  assign lo_x      = num_x_r[OUT_W-1:0];
  assign lo_z      = num_z_r[OUT_W-1:0];
  assign trial_x   = {rem_x_r, lo_x[cnt_r]};
  assign trial_z   = {rem_z_r, lo_z[cnt_r]};
  assign ge_x      = trial_x >= {1'b0, den_r};
  assign ge_z      = trial_z >= {1'b0, den_r};
  // quotient overflows 16 bits when num >= den * 2^16
  assign chk_sat_x = ACC_W'(num_x_r[NUM_W-1:OUT_W]) >= den_r;
  assign chk_sat_z = ACC_W'(num_z_r[NUM_W-1:OUT_W]) >= den_r;
  assign out_free  = !out_valid_r || out_ready;

  assign q_pop             = (state_r == S_IDLE) && q_valid;
  assign out_valid         = out_valid_r;
  assign out_tristimulus_x = res_x_r;
  assign out_tristimulus_z = res_z_r;
  assign out_status        = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            num_x_r <= NUM_W'(target) * NUM_W'(q_data.x);
            num_z_r <= NUM_W'(target) * NUM_W'(q_data.z);
            den_r   <= q_data.y;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          yzero_r <= (den_r == '0);
          sat_x_r <= chk_sat_x;
          sat_z_r <= chk_sat_z;
          rem_x_r <= chk_sat_x ? '0 : ACC_W'(num_x_r[NUM_W-1:OUT_W]);
          rem_z_r <= chk_sat_z ? '0 : ACC_W'(num_z_r[NUM_W-1:OUT_W]);
          cnt_r   <= CNT_W'(OUT_W - 1);
          state_r <= (den_r == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          rem_x_r <= ge_x ? ACC_W'(trial_x - {1'b0, den_r}) : trial_x[ACC_W-1:0];
          rem_z_r <= ge_z ? ACC_W'(trial_z - {1'b0, den_r}) : trial_z[ACC_W-1:0];
          quo_x_r <= {quo_x_r[OUT_W-2:0], ge_x};
          quo_z_r <= {quo_z_r[OUT_W-2:0], ge_z};
          cnt_r   <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (yzero_r) begin
              res_x_r  <= '0;
              res_z_r  <= '0;
              status_r <= sti_pkg::STATUS_YZERO;
            end else begin
              res_x_r  <= sat_x_r ? sti_pkg::OUT_MAX : quo_x_r;
              res_z_r  <= sat_z_r ? sti_pkg::OUT_MAX : quo_z_r;
              status_r <= (sat_x_r || sat_z_r) ? sti_pkg::STATUS_SAT : sti_pkg::STATUS_OK;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
